// File: src/ticket_queue_with_id_recycling_macros.svh
// ----------------------------------------------------------------------------
// Ticket queue assertion macros
// Concurrent assertion shorthands used by the ticket queue top level.
// ----------------------------------------------------------------------------
`ifndef TICKET_QUEUE_WITH_ID_RECYCLING_MACROS_SVH
`define TICKET_QUEUE_WITH_ID_RECYCLING_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TQIR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error(msg);

`define TQIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`else

`define TQIR_ASSERT(lbl, expr, msg)

`define TQIR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/tqir_pkg.sv
// ----------------------------------------------------------------------------
// Ticket queue package
// Operation codes, cell command codes and link flags shared by the top level and the cells.
// ----------------------------------------------------------------------------
package tqir_pkg;

	localparam logic [1:0] OP_ISSUE   = 2'd0;
	localparam logic [1:0] OP_SERVE   = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;
	localparam logic [1:0] OP_PROMOTE = 2'd3;

	typedef enum logic [2:0] {
		Q_HOLD,
		Q_MATCH,
		Q_PREFIX,
		Q_APPEND,
		Q_SERVE,
		Q_REMOVE,
		Q_PROMOTE
	} qcmd_t;

	typedef enum logic [1:0] {
		S_HOLD,
		S_PUSH,
		S_POP
	} scmd_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} qflag_t;

endpackage

// File: src/tqir_qcell.sv
// ----------------------------------------------------------------------------
// Ticket queue cell
// One queue position: holds a ticket ID, its valid flag and a match flag.
// ----------------------------------------------------------------------------
module tqir_qcell #(
	parameter int ID_W = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tqir_pkg::qcmd_t    cmd,
	input  logic [ID_W-1:0]    bcast_id,
	input  logic [ID_W-1:0]    left_id,
	input  tqir_pkg::qflag_t   left_flags,
	input  logic [ID_W-1:0]    right_id,
	input  tqir_pkg::qflag_t   right_flags,
	input  logic [2:0]         far_hit,
	output logic [ID_W-1:0]    id,
	output tqir_pkg::qflag_t   flags
);
	import tqir_pkg::*;

	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] id_d;
	qflag_t          flags_q;
	qflag_t          flags_d;

	always_comb begin
		id_d    = id_q;
		flags_d = flags_q;
		unique case (cmd)
			Q_HOLD: begin
			end
			Q_MATCH: begin
				flags_d.hit = flags_q.valid && (id_q == bcast_id);
			end
			Q_PREFIX: begin
				flags_d.hit = flags_q.hit || (|far_hit);
			end
			Q_APPEND: begin
				if (left_flags.valid && !flags_q.valid) begin
					id_d          = bcast_id;
					flags_d.valid = 1'b1;
				end
			end
			Q_SERVE: begin
				id_d          = right_id;
				flags_d.valid = right_flags.valid;
			end
			Q_REMOVE: begin
				if (flags_q.hit) begin
					id_d          = right_id;
					flags_d.valid = right_flags.valid;
				end
			end
			Q_PROMOTE: begin
				if (!left_flags.hit) begin
					id_d = left_id;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
	end

	assign id    = id_q;
	assign flags = flags_q;

endmodule

// File: src/tqir_scell.sv
// ----------------------------------------------------------------------------
// Recycle stack cell
// One stack slot: holds a recycled ticket ID and its valid flag.
// ----------------------------------------------------------------------------
module tqir_scell #(
	parameter int ID_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tqir_pkg::scmd_t  cmd,
	input  logic [ID_W-1:0]  left_id,
	input  logic             left_valid,
	input  logic [ID_W-1:0]  right_id,
	input  logic             right_valid,
	output logic [ID_W-1:0]  id,
	output logic             valid
);
	import tqir_pkg::*;

	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] id_d;
	logic            valid_q;
	logic            valid_d;

	always_comb begin
		id_d    = id_q;
		valid_d = valid_q;
		unique case (cmd)
			S_HOLD: begin
			end
			S_PUSH: begin
				id_d    = left_id;
				valid_d = left_valid;
			end
			S_POP: begin
				id_d    = right_id;
				valid_d = right_valid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
	end

	assign id    = id_q;
	assign valid = valid_q;

endmodule

// File: src/ticket_queue_with_id_recycling.sv
// ----------------------------------------------------------------------------
// Ticket queue with ID recycling
// Ordered ticket queue in a row of cells, with a row of cells as the stack
// of recycled IDs.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low, and its result
// appears for exactly one cycle with done high, in the first cycle in which
// busy is low again; the receiver cannot stall, so it must take every result
// when done is high.
// Issue and serve go from idle straight to the apply state. Remove and promote
// pass through a match state and a prefix state before apply, since the
// matching cell is found by a radix-4 prefix of match flags that passes along
// the queue row, one radix step per cycle. An out-of-range ticket skips the
// match and prefix states. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "ticket_queue_with_id_recycling_macros.svh"

module ticket_queue_with_id_recycling #(
	parameter int MAX_TICKETS = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [7:0] ticket_id,
	output logic       done,
	output logic [7:0] result_id,
	output logic       success,
	output logic [8:0] queue_length
);
	import tqir_pkg::*;

	localparam int ID_W   = $clog2(MAX_TICKETS);
	localparam int CNT_W  = $clog2(MAX_TICKETS + 1);
	localparam int PSTEPS = (ID_W + 1) / 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_PREFIX,
		ST_APPLY
	} state_t;

	state_t            state_q;
	logic [1:0]        op_q;
	logic [7:0]        tid_q;
	logic              in_range_q;
	logic [PSTEPS-1:0] step_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic [7:0]        result_id_q;
	logic              success_q;
	logic [8:0]        queue_length_q;

	logic [ID_W-1:0]        q_id [MAX_TICKETS];
	qflag_t                 q_flags [MAX_TICKETS];
	logic [ID_W-1:0]        s_id [MAX_TICKETS];
	logic                   s_valid [MAX_TICKETS];
	logic [MAX_TICKETS-1:0] q_valid_vec;
	logic [MAX_TICKETS-1:0] s_valid_vec;

	qcmd_t            q_cmd;
	scmd_t            s_cmd;
	logic [ID_W-1:0]  tid_id;
	logic [ID_W-1:0]  new_id;
	logic [ID_W-1:0]  q_bcast;
	logic [ID_W-1:0]  s_bcast;
	logic             in_range;
	logic             full;
	logic             empty;
	logic             found;
	logic             ok;
	logic [7:0]       rid;
	logic [CNT_W-1:0] count_d;

	always_comb begin
		for (int i = 0; i < MAX_TICKETS; i++) begin
			q_valid_vec[i] = q_flags[i].valid;
			s_valid_vec[i] = s_valid[i];
		end
	end

	assign in_range = 32'(ticket_id) < 32'(MAX_TICKETS);
	assign tid_id   = ID_W'(tid_q);
	assign new_id   = s_valid[0] ? s_id[0] : count_q[ID_W-1:0];
	assign full     = count_q == CNT_W'(MAX_TICKETS);
	assign empty    = count_q == '0;
	assign found    = in_range_q && q_flags[MAX_TICKETS-1].hit;
	assign q_bcast  = (op_q == OP_ISSUE) ? new_id : tid_id;
	assign s_bcast  = (op_q == OP_SERVE) ? q_id[0] : tid_id;

	always_comb begin
		q_cmd   = Q_HOLD;
		s_cmd   = S_HOLD;
		ok      = 1'b0;
		rid     = '0;
		count_d = count_q;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_MATCH: begin
				q_cmd = Q_MATCH;
			end
			ST_PREFIX: begin
				q_cmd = Q_PREFIX;
			end
			ST_APPLY: begin
				unique case (op_q)
					OP_ISSUE: begin
						if (!full) begin
							q_cmd   = Q_APPEND;
							s_cmd   = s_valid[0] ? S_POP : S_HOLD;
							count_d = CNT_W'(count_q + 1'b1);
							rid     = 8'(new_id);
							ok      = 1'b1;
						end
					end
					OP_SERVE: begin
						if (!empty) begin
							q_cmd   = Q_SERVE;
							s_cmd   = S_PUSH;
							count_d = CNT_W'(count_q - 1'b1);
							rid     = 8'(q_id[0]);
							ok      = 1'b1;
						end
					end
					OP_REMOVE: begin
						rid = tid_q;
						if (found) begin
							q_cmd   = Q_REMOVE;
							s_cmd   = S_PUSH;
							count_d = CNT_W'(count_q - 1'b1);
							ok      = 1'b1;
						end
					end
					OP_PROMOTE: begin
						rid = tid_q;
						if (found) begin
							q_cmd = Q_PROMOTE;
							ok    = 1'b1;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_ISSUE;
			tid_q          <= '0;
			in_range_q     <= 1'b0;
			step_q         <= '0;
			count_q        <= '0;
			done_q         <= 1'b0;
			result_id_q    <= '0;
			success_q      <= 1'b0;
			queue_length_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q       <= operation;
						tid_q      <= ticket_id;
						in_range_q <= in_range;
						if ((operation == OP_REMOVE || operation == OP_PROMOTE) && in_range) begin
							state_q <= ST_MATCH;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_MATCH: begin
					step_q  <= PSTEPS'(1);
					state_q <= ST_PREFIX;
				end
				ST_PREFIX: begin
					step_q <= step_q << 1;
					if (step_q[PSTEPS-1]) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					done_q         <= 1'b1;
					success_q      <= ok;
					result_id_q    <= rid;
					queue_length_q <= 9'(count_d);
					count_q        <= count_d;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	for (genvar i = 0; i < MAX_TICKETS; i++) begin : g_cell
		logic [ID_W-1:0] q_left_id;
		qflag_t          q_left_flags;
		logic [ID_W-1:0] q_right_id;
		qflag_t          q_right_flags;
		logic [ID_W-1:0] s_left_id;
		logic            s_left_valid;
		logic [ID_W-1:0] s_right_id;
		logic            s_right_valid;
		logic [2:0]      far;

		if (i == 0) begin : g_first
			assign q_left_id    = q_bcast;
			assign q_left_flags = '{valid: 1'b1, hit: 1'b0};
			assign s_left_id    = s_bcast;
			assign s_left_valid = 1'b1;
		end else begin : g_inner
			assign q_left_id    = q_id[i-1];
			assign q_left_flags = q_flags[i-1];
			assign s_left_id    = s_id[i-1];
			assign s_left_valid = s_valid[i-1];
		end

		if (i == MAX_TICKETS - 1) begin : g_last
			assign q_right_id    = '0;
			assign q_right_flags = '0;
			assign s_right_id    = '0;
			assign s_right_valid = 1'b0;
		end else begin : g_body
			assign q_right_id    = q_id[i+1];
			assign q_right_flags = q_flags[i+1];
			assign s_right_id    = s_id[i+1];
			assign s_right_valid = s_valid[i+1];
		end

		always_comb begin
			far = '0;
			for (int k = 0; k < PSTEPS; k++) begin
				for (int j = 1; j <= 3; j++) begin
					if (step_q[k] && (i - j * (4 ** k)) >= 0) begin
						far[j-1] = far[j-1] | q_flags[i - j * (4 ** k)].hit;
					end
				end
			end
		end

		tqir_qcell #(
			.ID_W(ID_W)
		) u_qcell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (q_cmd),
			.bcast_id   (q_bcast),
			.left_id    (q_left_id),
			.left_flags (q_left_flags),
			.right_id   (q_right_id),
			.right_flags(q_right_flags),
			.far_hit    (far),
			.id         (q_id[i]),
			.flags      (q_flags[i])
		);

		tqir_scell #(
			.ID_W(ID_W)
		) u_scell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (s_cmd),
			.left_id    (s_left_id),
			.left_valid (s_left_valid),
			.right_id   (s_right_id),
			.right_valid(s_right_valid),
			.id         (s_id[i]),
			.valid      (s_valid[i])
		);
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign result_id    = result_id_q;
	assign success      = success_q;
	assign queue_length = queue_length_q;

	`TQIR_ASSERT(a_count_matches_cells, 32'(count_q) == $countones(q_valid_vec), "queue count differs from occupied cells")
	`TQIR_ASSERT(a_ids_bounded, ($countones(q_valid_vec) + $countones(s_valid_vec)) <= MAX_TICKETS, "more live IDs than tickets")
	`TQIR_ASSERT_NEXT(a_apply_strobes, state_q == ST_APPLY, done_q && state_q == ST_IDLE, "apply did not produce a result")
	`TQIR_ASSERT(a_strobe_after_apply, !done_q || $past(state_q) == ST_APPLY, "result strobe without apply")

endmodule
